// ===== src/gaussian_rbf_kernel_eval_macros.svh =====
// assertion macros used by the checker file
`ifndef GAUSSIAN_RBF_KERNEL_EVAL_MACROS_SVH
`define GAUSSIAN_RBF_KERNEL_EVAL_MACROS_SVH

// property checked on every rising clock edge, masked while reset is high
`define GRBF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define GRBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/grbf_pkg.sv =====
package grbf_pkg;

  localparam int X_W      = 16;
  localparam int GAMMA_W  = 24;
  localparam int KERNEL_W = 17;
  localparam int DIST_W   = 46;
  localparam int SQ_W     = 32;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd1638;

  // distance saturation bound
  localparam longint unsigned MAX_FEATURES = 64'd16384;
  localparam longint unsigned SQ_MAX       = 64'd4294836225;
  localparam longint unsigned D46_MAX      = 64'd70368744177663;
  localparam logic [DIST_W-1:0] DIST_CAP =
    (MAX_FEATURES * SQ_MAX > D46_MAX) ? DIST_W'(D46_MAX) : DIST_W'(MAX_FEATURES * SQ_MAX);

  // exponent evaluation, all Q.32 but for the taylor term count
  localparam int T_W = 54;
  localparam int R_W = 36;
  localparam logic [T_W-1:0] T_ZERO_LIMIT = 54'd51539607552;
  localparam logic [R_W-1:0] LN2_Q32      = 36'd2977044472;
  localparam logic [32:0]    ONE_Q32      = 33'h1_0000_0000;
  localparam logic [3:0]     TAYLOR_TERMS = 4'd13;

  // taylor term divider
  localparam int DIV_W      = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic              push;
    logic [DIST_W-1:0] distance;
  } q_wr_t;

  typedef struct packed {
    logic              nonempty;
    logic [DIST_W-1:0] distance;
  } q_rd_t;

endpackage

// ===== src/grbf_ifaces.sv =====
interface grbf_in_if;
  logic                     valid;
  logic                     ready;
  logic [grbf_pkg::X_W-1:0] x_feature;
  logic [grbf_pkg::X_W-1:0] y_feature;
  logic                     last_pair;
  modport source (output valid, x_feature, y_feature, last_pair, input ready);
  modport sink   (input valid, x_feature, y_feature, last_pair, output ready);
endinterface

interface grbf_out_if;
  logic                          valid;
  logic                          ready;
  logic [grbf_pkg::KERNEL_W-1:0] kernel_value;
  logic [grbf_pkg::DIST_W-1:0]   sq_distance;
  modport source (output valid, kernel_value, sq_distance, input ready);
  modport sink   (input valid, kernel_value, sq_distance, output ready);
endinterface

interface grbf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [grbf_pkg::GAMMA_W-1:0] gamma;
  modport source (output valid, gamma, input ready);
  modport sink   (input valid, gamma, output ready);
endinterface

// ===== src/grbf_queue.sv =====
module grbf_queue #(
  parameter int DEPTH = grbf_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  grbf_pkg::q_wr_t wr,
  input  logic            pop,
  output grbf_pkg::q_rd_t rd,
  output logic [CW-1:0]   level
);

  logic [grbf_pkg::DIST_W-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.distance;
    end
  end

  assign rd.nonempty = (count != '0);
  assign rd.distance = mem[rd_ptr];
  assign level       = count;

endmodule

// ===== src/grbf_div.sv =====
module grbf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [grbf_pkg::DIV_W-1:0] dividend,
  input  logic [3:0]                 divisor,
  output logic                       done,
  output logic [grbf_pkg::DIV_W-1:0] quotient
);

  localparam int CNTW = (grbf_pkg::DIV_CYCLES > 1) ? $clog2(grbf_pkg::DIV_CYCLES) : 1;

  logic [grbf_pkg::DIV_W-1:0] quo;
  logic [grbf_pkg::DIV_W-1:0] quo_next;
  logic [3:0]                 rem;
  logic [3:0]                 rem_next;
  logic [CNTW-1:0]            cnt;
  logic                       busy;

  // restoring division, DIV_STEP quotient bits per cycle while busy
  always_comb begin
    logic [4:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < grbf_pkg::DIV_STEP; i++) begin
      trial    = {rem_next, quo_next[grbf_pkg::DIV_W-1]};
      quo_next = {quo_next[grbf_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = 4'(trial - {1'b0, divisor});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(grbf_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== src/grbf_front.sv =====
module grbf_front #(
  parameter int DEPTH = grbf_pkg::QUEUE_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  grbf_cfg_if.sink                     cfg,
  grbf_in_if.sink                      pair_in,
  input  logic [CW-1:0]                level,
  output grbf_pkg::q_wr_t              wr,
  output logic [grbf_pkg::GAMMA_W-1:0] gamma
);

  logic                        s1_valid;
  logic                        s1_last;
  logic [grbf_pkg::SQ_W-1:0]   sq;
  logic [grbf_pkg::DIST_W-1:0] acc;
  logic [grbf_pkg::DIST_W:0]   acc_sum;
  logic [grbf_pkg::DIST_W-1:0] acc_sat;
  logic [grbf_pkg::X_W-1:0]    diff;
  logic                        pending;
  logic                        accept;

  assign cfg.ready = 1'b1;

  // a word in the square stage may still need a queue slot
  assign pending       = s1_valid & s1_last;
  assign pair_in.ready = ({1'b0, level} + (CW + 1)'(pending)) < (CW + 1)'(DEPTH);
  assign accept        = pair_in.valid & pair_in.ready;

  assign diff = (pair_in.x_feature >= pair_in.y_feature) ?
                pair_in.x_feature - pair_in.y_feature :
                pair_in.y_feature - pair_in.x_feature;

  assign acc_sum = {1'b0, acc} + (grbf_pkg::DIST_W + 1)'(sq);
  assign acc_sat = (acc_sum > {1'b0, grbf_pkg::DIST_CAP}) ?
                   grbf_pkg::DIST_CAP : acc_sum[grbf_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma    <= grbf_pkg::GAMMA_RESET;
      s1_valid <= 1'b0;
      acc      <= '0;
    end else begin
      if (cfg.valid) begin
        gamma <= cfg.gamma;
      end
      s1_valid <= accept;
      if (s1_valid) begin
        acc <= s1_last ? '0 : acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq      <= grbf_pkg::SQ_W'(diff) * grbf_pkg::SQ_W'(diff);
      s1_last <= pair_in.last_pair;
    end
  end

  assign wr.push     = s1_valid & s1_last;
  assign wr.distance = acc_sat;

endmodule

// ===== src/grbf_back.sv =====
module grbf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [grbf_pkg::GAMMA_W-1:0] gamma,
  input  grbf_pkg::q_rd_t              rd,
  output logic                         pop,
  grbf_out_if.source                   result_out
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MLO   = 4'd1;
  localparam logic [3:0] S_MHI   = 4'd2;
  localparam logic [3:0] S_TSUM  = 4'd3;
  localparam logic [3:0] S_RED   = 4'd4;
  localparam logic [3:0] S_TMUL  = 4'd5;
  localparam logic [3:0] S_TDIV  = 4'd6;
  localparam logic [3:0] S_TWAIT = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int T_W = grbf_pkg::T_W;
  localparam int R_W = grbf_pkg::R_W;

  logic [3:0]                    state;
  logic                          out_valid;
  logic [grbf_pkg::DIST_W-1:0]   d;
  logic [39:0]                   lo;
  logic [64:0]                   prod;
  logic [32:0]                   mul_a;
  logic [31:0]                   mul_b;
  logic [R_W-1:0]                r;
  logic [4:0]                    k;
  logic [32:0]                   term;
  logic [33:0]                   sum;
  logic [3:0]                    n;
  logic [grbf_pkg::KERNEL_W-1:0] kernel;
  logic [T_W-1:0]                t;
  logic [33:0]                   rnd;
  logic [grbf_pkg::KERNEL_W-1:0] kernel_fin;
  logic                          div_start;
  logic                          div_done;
  logic [grbf_pkg::DIV_W-1:0]    div_quo;

  grbf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[63:32]),
    .divisor  (n),
    .done     (div_done),
    .quotient (div_quo)
  );

  // one shared multiplier: gamma times distance halves, then term times r
  always_comb begin
    case (state)
      S_MLO: begin
        mul_a = 33'(gamma);
        mul_b = d[31:0];
      end
      S_MHI: begin
        mul_a = 33'(gamma);
        mul_b = 32'(d[grbf_pkg::DIST_W-1:32]);
      end
      default: begin
        mul_a = term;
        mul_b = r[31:0];
      end
    endcase
  end

  assign t          = {prod[37:0], 16'b0} + T_W'(lo);
  assign rnd        = sum + (34'd1 << (6'(k) + 6'd15));
  assign kernel_fin = grbf_pkg::KERNEL_W'(rnd >> (6'(k) + 6'd16));
  assign div_start  = (state == S_TDIV);
  assign pop        = (state == S_IDLE) & rd.nonempty;

  always_ff @(posedge clk) begin
    prod <= 65'(mul_a) * 65'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (rd.nonempty) begin
            state <= S_MLO;
          end
        end
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_TSUM;
        S_TSUM: begin
          if (t >= grbf_pkg::T_ZERO_LIMIT) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          if (r < grbf_pkg::LN2_Q32) begin
            state <= S_TMUL;
          end
        end
        S_TMUL: state <= S_TDIV;
        S_TDIV: state <= S_TWAIT;
        S_TWAIT: begin
          if (div_done) begin
            state <= (n == grbf_pkg::TAYLOR_TERMS) ? S_FIN : S_TMUL;
          end
        end
        S_FIN: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (result_out.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (rd.nonempty) begin
          d <= rd.distance;
        end
      end
      S_MHI: lo <= prod[55:16];
      S_TSUM: begin
        kernel <= '0;
        r      <= t[R_W-1:0];
        k      <= '0;
      end
      S_RED: begin
        if (r >= grbf_pkg::LN2_Q32) begin
          r <= r - grbf_pkg::LN2_Q32;
          k <= k + 1'b1;
        end else begin
          term <= grbf_pkg::ONE_Q32;
          sum  <= {1'b0, grbf_pkg::ONE_Q32};
          n    <= 4'd1;
        end
      end
      S_TWAIT: begin
        if (div_done) begin
          term <= {1'b0, div_quo};
          sum  <= n[0] ? sum - 34'(div_quo) : sum + 34'(div_quo);
          n    <= n + 1'b1;
        end
      end
      S_FIN: kernel <= kernel_fin;
      default: begin
      end
    endcase
  end

  assign result_out.valid        = out_valid;
  assign result_out.kernel_value = kernel;
  assign result_out.sq_distance  = d;

endmodule

// ===== src/gaussian_rbf_kernel_eval.sv =====
// flow: a taken last word is squared into the front stage register, then pushed into the queue;
// the back pops it, multiplies gamma by both distance halves and either returns a zero kernel
// or reduces by ln2 up to 17 times and sums 13 taylor terms, each through the term divider
// throughput: one feature word per cycle while the queue has room; the back takes no new
// distance until its result word is taken; short vectors wait on the exponent unit via the queue
// reset: synchronous rst clears accumulator, queue, sequencer and result valid, gamma to 1638
module gaussian_rbf_kernel_eval #(
  parameter int QUEUE_DEPTH = grbf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  grbf_cfg_if.sink   cfg,
  grbf_in_if.sink    pair_in,
  grbf_out_if.source result_out
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // front to queue: one distance word per finished vector
  grbf_pkg::q_wr_t              q_wr;
  // queue head seen by the exponent unit
  grbf_pkg::q_rd_t              q_rd;
  logic                         q_pop;
  // fill level, the front stalls input before the queue can overflow
  logic [CW-1:0]                q_level;
  // kernel scale, read live by the back; the user must change it only while idle, the block does not enforce it
  logic [grbf_pkg::GAMMA_W-1:0] gamma;

  // front: |x-y|^2 in one stage, saturating accumulate in the next,
  // pushes the distance on the last word and clears
  grbf_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pair_in (pair_in),
    .level   (q_level),
    .wr      (q_wr),
    .gamma   (gamma)
  );

  // short queue of finished distances, decouples streaming from the exponent
  grbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .pop   (q_pop),
    .rd    (q_rd),
    .level (q_level)
  );

  // back: t = gamma*d, range reduction by ln2, taylor series for exp(-r),
  // then scale by 2^-k with round half up, zero once t reaches 12; result held in an output register
  grbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .gamma      (gamma),
    .rd         (q_rd),
    .pop        (q_pop),
    .result_out (result_out)
  );

endmodule

// ===== src/grbf_checker.sv =====
`include "gaussian_rbf_kernel_eval_macros.svh"

module grbf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [grbf_pkg::KERNEL_W-1:0] kernel_value,
  input logic [grbf_pkg::DIST_W-1:0]   sq_distance
);

  // no result word survives a reset
  `GRBF_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

  // a stalled result word holds
  `GRBF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(kernel_value) && $stable(sq_distance), "result changed while stalled")

  // kernel never above 1.0
  `GRBF_ASSERT(a_kernel_range, clk, rst, out_valid |-> kernel_value <= 17'd65536, "kernel above one")

  // identical vectors give exactly 1.0
  `GRBF_ASSERT(a_zero_dist, clk, rst, out_valid && sq_distance == '0 |-> kernel_value == 17'd65536, "zero distance kernel not one")

  // distance respects the saturation bound
  `GRBF_ASSERT(a_dist_cap, clk, rst, out_valid |-> sq_distance <= grbf_pkg::DIST_CAP, "distance above cap")

endmodule

bind gaussian_rbf_kernel_eval grbf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .kernel_value (result_out.kernel_value),
  .sq_distance  (result_out.sq_distance)
);

// ===== verif/tb_gaussian_rbf_kernel_eval.sv =====
module tb_gaussian_rbf_kernel_eval;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int X_W      = grbf_pkg::X_W;
  localparam int GAMMA_W  = grbf_pkg::GAMMA_W;
  localparam int KERNEL_W = grbf_pkg::KERNEL_W;
  localparam int DIST_W   = grbf_pkg::DIST_W;

  // percent of cycles in which a side idles
  localparam int IDLE_PCT = 6;
  // quiet cycles before a gamma write and after the last result
  localparam int DRAIN_CYCLES = 20;
  localparam int END_TAIL = 200;
  // receiver hold-off that lets the distance queue fill up
  localparam int HOLD_CYCLES = 1200;
  // random stimulus size
  localparam int RANDOM_WORDS = 1800;
  // a run far slower than this is hung
  localparam longint unsigned RUN_LIMIT_NS = 64'd4_000_000;
  // only the first mismatches get a line of their own
  localparam int MAX_REPORTS = 40;

  // distance saturation bound, the full sum of MAX_FEATURES worst squares
  localparam longint unsigned SUM_CAP =
    (grbf_pkg::MAX_FEATURES * grbf_pkg::SQ_MAX > grbf_pkg::D46_MAX) ?
    grbf_pkg::D46_MAX : grbf_pkg::MAX_FEATURES * grbf_pkg::SQ_MAX;
  localparam longint unsigned PAIR_COUNT_MAX = 64'd32767;
  localparam longint unsigned Q32_ONE = 64'h1_0000_0000;

  typedef enum int {PAIR_ANY, PAIR_NEAR, PAIR_EDGE, PAIR_SAME} pair_mode_e;

  typedef struct {
    bit [KERNEL_W-1:0] kernel;
    bit [DIST_W-1:0]   sq_dist;
  } kernel_result_t;

  logic clk;
  logic rst;

  grbf_cfg_if cfg_if();
  grbf_in_if  pair_if();
  grbf_out_if result_if();

  gaussian_rbf_kernel_eval DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_if),
    .pair_in   (pair_if),
    .result_out(result_if)
  );

  // model copy of the register and the running state
  bit [GAMMA_W-1:0]  gamma_now;
  longint unsigned   dist_sum;
  longint unsigned   pairs_in_vector;

  // kernel results still owed by the block, oldest first
  kernel_result_t    pending_kernels[$];

  int unsigned       mismatches;
  int unsigned       words_sent;
  int unsigned       results_seen;
  int unsigned       gamma_writes;

  // idling switch shared by both sides, and the hold-off request
  bit                no_idle;
  bit                hold_req;
  logic              hold_off;

  always #2 clk = ~clk;

  // ------------------------------------------------------------------
  // kernel arithmetic: exp(-gamma*d) in fixed point
  // ------------------------------------------------------------------
  function automatic bit [KERNEL_W-1:0] kernel_of_distance(input bit [GAMMA_W-1:0] g,
                                                           input longint unsigned d);
    longint unsigned gw;
    longint unsigned t;
    longint unsigned k;
    longint unsigned r;
    longint unsigned term;
    longint unsigned sum;
    int n;
    gw = longint'(g);
    // gamma*d scaled back to Q.32, split so that nothing overflows 64 bits
    t = ((gw * (d >> 32)) << 16) + ((gw * (d & 64'hFFFF_FFFF)) >> 16);
    // far tail: rounds to zero
    if (t >= longint'(grbf_pkg::T_ZERO_LIMIT)) return '0;
    // range reduction by ln 2, then the taylor series on the remainder
    k = t / longint'(grbf_pkg::LN2_Q32);
    r = t - k * longint'(grbf_pkg::LN2_Q32);
    term = Q32_ONE;
    sum = Q32_ONE;
    for (n = 1; n <= int'(grbf_pkg::TAYLOR_TERMS); n++) begin
      term = ((term * r) >> 32) / longint'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    // scale by 2^-k and drop to Q1.16, rounding half up
    return KERNEL_W'((sum + (64'd1 << (15 + k))) >> (16 + k));
  endfunction

  // fold one accepted word into the distance; a last word closes the vector
  task automatic fold_pair(input bit [X_W-1:0] x, input bit [X_W-1:0] y, input bit is_last);
    longint unsigned diff;
    kernel_result_t  res;
    diff = (x >= y) ? longint'(x - y) : longint'(y - x);
    dist_sum = dist_sum + diff * diff;
    // accumulator overflow saturates
    if (dist_sum > SUM_CAP) dist_sum = SUM_CAP;
    if (pairs_in_vector < PAIR_COUNT_MAX) pairs_in_vector++;
    if (is_last) begin
      res.kernel  = kernel_of_distance(gamma_now, dist_sum);
      res.sq_dist = DIST_W'(dist_sum);
      pending_kernels = {pending_kernels, res};
      dist_sum = 0;
      pairs_in_vector = 0;
    end
  endtask

  // ------------------------------------------------------------------
  // mismatch reporting and result checking
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  task automatic check_result(input logic [KERNEL_W-1:0] kv, input logic [DIST_W-1:0] sd);
    kernel_result_t want;
    int             delta;
    results_seen++;
    if (pending_kernels.size() == 0) begin
      report_mismatch($sformatf("result word with nothing pending (kernel %0d dist %0d)",
                                kv, sd));
      return;
    end
    want = pending_kernels.pop_front();
    if ($isunknown(sd) || sd != want.sq_dist)
      report_mismatch($sformatf("sq_distance %0d, want %0d", sd, want.sq_dist));
    // the fixed-point kernel may be off by one lsb
    if ($isunknown(kv)) begin
      report_mismatch($sformatf("kernel_value unknown, want %0d", want.kernel));
    end else begin
      delta = int'(kv) - int'(want.kernel);
      if (delta > 1 || delta < -1)
        report_mismatch($sformatf("kernel_value %0d, want %0d (dist %0d)",
                                  kv, want.kernel, want.sq_dist));
    end
  endtask

  // result side: check the word taken at this edge, then pick next ready
  always @(posedge clk) begin
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1)
      check_result(result_if.kernel_value, result_if.sq_distance);
    result_if.ready <= !hold_off && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  // receiver hold-off, counted in its own process
  initial begin
    hold_off = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  // offer one word, with random idle cycles ahead of it, until it is taken
  task automatic send_pair(input bit [X_W-1:0] x, input bit [X_W-1:0] y, input bit is_last);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pair_if.valid <= 1'b0;
      @(posedge clk);
    end
    pair_if.valid     <= 1'b1;
    pair_if.x_feature <= x;
    pair_if.y_feature <= y;
    pair_if.last_pair <= is_last;
    @(posedge clk);
    while (pair_if.ready !== 1'b1) @(posedge clk);
    fold_pair(x, y, is_last);
    words_sent++;
  endtask

  task automatic pick_pair(input pair_mode_e mode, output bit [X_W-1:0] x,
                           output bit [X_W-1:0] y);
    int v;
    x = X_W'($urandom);
    case (mode)
      PAIR_NEAR: begin
        // small differences keep the kernel away from zero
        v = int'(x) + int'($urandom_range(1024)) - 512;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        y = X_W'(v);
      end
      PAIR_EDGE: begin
        x = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(3) == 0) x = x ^ 16'h0001;
        if ($urandom_range(3) == 0) y = y ^ 16'h0001;
      end
      PAIR_SAME: begin
        y = x;
      end
      default: begin
        y = X_W'($urandom);
      end
    endcase
  endtask

  task automatic send_vector(input int len, input pair_mode_e mode);
    bit [X_W-1:0] x;
    bit [X_W-1:0] y;
    int i;
    for (i = 0; i < len; i++) begin
      pick_pair(mode, x, y);
      send_pair(x, y, i == len - 1);
    end
  endtask

  // stop offering, wait out every pending result, then let the block go quiet
  task automatic drain_block();
    pair_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_kernels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // gamma is only written with the block idle
  task automatic write_gamma(input bit [GAMMA_W-1:0] value);
    drain_block();
    cfg_if.valid <= 1'b1;
    cfg_if.gamma <= value;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    gamma_now = value;
    gamma_writes++;
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  // field extremes under the reset gamma, no register write yet
  task automatic test_reset_gamma();
    send_pair(16'h0000, 16'h0000, 1'b1);   // zero distance, kernel of one
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h0001, 16'h0000, 1'b1);   // smallest nonzero distance
    drain_block();
  endtask

  // gamma at both ends and at 1.0
  task automatic test_gamma_extremes();
    write_gamma('0);                        // kernel is one whatever the distance
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    write_gamma({GAMMA_W{1'b1}});           // largest scale
    send_pair(16'h0001, 16'h0000, 1'b1);
    send_pair(16'h0100, 16'h0000, 1'b1);
    send_pair(16'h1234, 16'h1234, 1'b1);
    write_gamma(24'h01_0000);               // gamma of 1.0, t equals d
    send_pair(16'hB505, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
  endtask

  // gamma*d straddling 12.0, where the kernel is forced to zero
  task automatic test_zero_limit();
    int g;
    for (g = 786454; g <= 786459; g++) begin
      write_gamma(GAMMA_W'(g));
      send_pair(16'hFFFF, 16'h0000, 1'b1);
    end
  endtask

  // receiver holds off while short vectors keep coming, so the input stalls
  task automatic test_backpressure();
    int v;
    write_gamma(24'h00_4000);
    hold_req = 1'b1;
    for (v = 0; v < 12; v++) send_vector(2, PAIR_NEAR);
    drain_block();
  endtask

  // random vectors under changing gamma settings
  task automatic test_random();
    int  since_write;
    int  len;
    int  pick;
    bit [GAMMA_W-1:0] g;
    pair_mode_e mode;
    since_write = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (since_write > 250) begin
        pick = $urandom_range(9);
        if (pick < 3)      g = GAMMA_W'($urandom);
        else if (pick < 6) g = GAMMA_W'($urandom_range(65535));
        else if (pick < 8) g = GAMMA_W'($urandom_range(4095));
        else if (pick < 9) g = grbf_pkg::GAMMA_RESET;
        else               g = $urandom_range(1) ? '0 : {GAMMA_W{1'b1}};
        write_gamma(g);
        since_write = 0;
      end
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(16, 1);
      else if (pick < 95) len = $urandom_range(64, 17);
      else                len = $urandom_range(300, 65);
      pick = $urandom_range(9);
      if (pick < 4)      mode = PAIR_ANY;
      else if (pick < 8) mode = PAIR_NEAR;
      else if (pick < 9) mode = PAIR_EDGE;
      else               mode = PAIR_SAME;
      // a stretch of the run with no idling on either side
      no_idle = (since_write > 60 && since_write < 200 && gamma_writes % 3 == 0);
      send_vector(len, mode);
      since_write += len;
    end
    no_idle = 1'b0;
    drain_block();
  endtask

  // ------------------------------------------------------------------
  // run
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.gamma = '0;
    pair_if.valid = 1'b0;
    pair_if.x_feature = '0;
    pair_if.y_feature = '0;
    pair_if.last_pair = 1'b0;
    result_if.ready = 1'b0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    gamma_now = grbf_pkg::GAMMA_RESET;
    dist_sum = 0;
    pairs_in_vector = 0;
    mismatches = 0;
    words_sent = 0;
    results_seen = 0;
    gamma_writes = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_gamma();
    test_gamma_extremes();
    test_zero_limit();
    test_backpressure();
    test_random();

    drain_block();
    repeat (END_TAIL) @(posedge clk);
    $display("covered %0d feature words, %0d kernel results, %0d gamma settings",
             words_sent, results_seen, gamma_writes);
    $display("including field extremes, the zero-kernel limit and a stalled result side");
    if (mismatches == 0 && pending_kernels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_kernels.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("timeout with %0d results pending", pending_kernels.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/grbf_pkg.sv
src/grbf_ifaces.sv
src/grbf_queue.sv
src/grbf_div.sv
src/grbf_front.sv
src/grbf_back.sv
src/gaussian_rbf_kernel_eval.sv
src/grbf_checker.sv
verif/tb_gaussian_rbf_kernel_eval.sv
